@@ design/lcs_pkg.sv @@
// Shared types and constants for the longest common substring block.
// No dependencies; imported by every module of the block.
package lcs_pkg;

	localparam int MAX_LEN = 64;
	localparam int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LW      = $clog2(MAX_LEN + 1);

	localparam logic [1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [6:0] match_length;
		logic [5:0] match_start;
		logic       overflow;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load_a;
		logic load_b;
		logic init;
		logic extend;
		logic end_run;
		logic finish;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic in_bounds;
		logic eq;
	} dp_sts_t;

endpackage

@@ design/lcs_datapath.sv @@
// Datapath: string buffers, scan counters, best-match tracking, result register.
// Depends on lcs_pkg.
module lcs_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       data_byte,
	input  lcs_pkg::dp_cmd_t dp_cmd,
	output lcs_pkg::dp_sts_t dp_sts,
	output lcs_pkg::rsp_t    rsp
);
	import lcs_pkg::*;

	logic [7:0]    mem_a [MAX_LEN];
	logic [7:0]    mem_b [MAX_LEN];
	logic [7:0]    rd_a_q, rd_b_q;
	logic [LW-1:0] len_a_q, len_b_q;
	logic          ovf_q;
	logic [LW-1:0] i_q, j_q, run_q;
	logic [LW-1:0] best_len_q, best_start_q;
	rsp_t          rsp_q;
	logic [LW:0]   pos_a, pos_b;
	logic          wr_a, wr_b;

	assign pos_a = {1'b0, j_q} + {1'b0, run_q};
	assign pos_b = {1'b0, i_q} + {1'b0, run_q};

	assign wr_a = dp_cmd.load_a && (data_byte != 8'd0) && (len_a_q < LW'(MAX_LEN));
	assign wr_b = dp_cmd.load_b && (data_byte != 8'd0) && (len_b_q < LW'(MAX_LEN));

	always_comb begin
		dp_sts.scan_done = (i_q >= len_b_q) || (len_a_q == '0);
		dp_sts.in_bounds = (pos_a < {1'b0, len_a_q}) && (pos_b < {1'b0, len_b_q});
		dp_sts.eq        = (rd_a_q == rd_b_q);
	end

	// buffers, registered read at the current scan position
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[len_a_q[AW-1:0]] <= data_byte;
		end
		if (wr_b) begin
			mem_b[len_b_q[AW-1:0]] <= data_byte;
		end
		rd_a_q <= mem_a[pos_a[AW-1:0]];
		rd_b_q <= mem_b[pos_b[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q <= '0;
			len_b_q <= '0;
			ovf_q   <= 1'b0;
		end else if (dp_cmd.finish) begin
			len_a_q <= '0;
			len_b_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (wr_a) begin
				len_a_q <= len_a_q + LW'(1);
			end
			if (wr_b) begin
				len_b_q <= len_b_q + LW'(1);
			end
			if ((dp_cmd.load_a && data_byte != 8'd0 && !wr_a) ||
			    (dp_cmd.load_b && data_byte != 8'd0 && !wr_b)) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// scan counters: B position outer, A position inner
	always_ff @(posedge clk) begin
		if (dp_cmd.init) begin
			i_q          <= '0;
			j_q          <= '0;
			run_q        <= '0;
			best_len_q   <= '0;
			best_start_q <= '0;
		end else if (dp_cmd.extend) begin
			run_q <= run_q + LW'(1);
		end else if (dp_cmd.end_run) begin
			if (run_q > best_len_q) begin
				best_len_q   <= run_q;
				best_start_q <= j_q;
			end
			run_q <= '0;
			if ((j_q + LW'(1)) == len_a_q) begin
				j_q <= '0;
				i_q <= i_q + LW'(1);
			end else begin
				j_q <= j_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.finish) begin
			rsp_q.match_length <= 7'(best_len_q);
			rsp_q.match_start  <= 6'(best_start_q);
			rsp_q.overflow     <= ovf_q;
		end
	end

	assign rsp = rsp_q;

endmodule

@@ design/lcs_ctrl.sv @@
// Controller FSM: request decode, scan sequencing, result valid.
// Depends on lcs_pkg; drives lcs_datapath through dp_cmd_t.
module lcs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [1:0]       req_cmd,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output lcs_pkg::dp_cmd_t dp_cmd,
	input  lcs_pkg::dp_sts_t dp_sts
);
	import lcs_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		CHECK,
		CMP,
		FINISH
	} state_t;

	state_t state_q;
	logic   req_xfer;
	logic   slot_free;

	assign req_ready = (state_q == IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign slot_free = !rsp_valid || rsp_ready;

	always_comb begin
		dp_cmd         = '0;
		dp_cmd.load_a  = req_xfer && (req_cmd == CMD_LOAD_A);
		dp_cmd.load_b  = req_xfer && (req_cmd == CMD_LOAD_B);
		dp_cmd.init    = req_xfer && (req_cmd == CMD_COMPUTE);
		dp_cmd.extend  = (state_q == CMP) && dp_sts.eq;
		dp_cmd.end_run = ((state_q == CMP) && !dp_sts.eq) ||
		                 ((state_q == CHECK) && !dp_sts.scan_done && !dp_sts.in_bounds);
		dp_cmd.finish  = (state_q == FINISH) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			rsp_valid <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (req_xfer && req_cmd == CMD_COMPUTE) begin
						state_q <= CHECK;
					end
				end
				CHECK: begin
					if (dp_sts.scan_done) begin
						state_q <= FINISH;
					end else if (dp_sts.in_bounds) begin
						state_q <= CMP;
					end
				end
				CMP: begin
					state_q <= CHECK;
				end
				FINISH: begin
					if (slot_free) begin
						rsp_valid <= 1'b1;
						state_q   <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_cmp_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CMP |-> $past(state_q) == CHECK)
		else $error("compare state not entered from check");

	a_finish_slot: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.finish |-> slot_free)
		else $error("result written while previous result pending");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.finish |=> rsp_valid && req_ready)
		else $error("finish did not present result");
`endif

endmodule

@@ design/longest_common_substring.sv @@
// Longest common substring search over two byte buffers (MAX_LEN bytes each).
// A compute posts its result once every (B pos, A pos) pair has been scanned; each compare
//   waits on a registered buffer read.
// Throughput: loads back to back; no request taken from a compute until it posts (which waits
//   while an earlier result is unread). Reset: clears lengths, overflow, FSM, result valid.
module longest_common_substring (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  lcs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output lcs_pkg::rsp_t rsp
);
	import lcs_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// controller: owns handshake and scan sequencing
	lcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_cmd   (req.cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts)
	);

	// datapath: buffers, counters, best match and result register
	lcs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (req.data_byte),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts),
		.rsp       (rsp)
	);

endmodule
